/* design/mfek_pkg.sv */
// Shared types and constants for the Edmonds-Karp maximum flow block.
// Used by mfek_ctrl, mfek_dp and max_flow_edmonds_karp; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package mfek_pkg;

  localparam int unsigned FLOW_W = 20;
  localparam int unsigned VIDX_W = 4;
  localparam int unsigned CAP_W = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SINK = 2'd2;

  typedef enum logic [3:0] {
    CMD_NOP,
    CMD_LOAD,
    CMD_CLR,
    CMD_INIT,
    CMD_BFS_START,
    CMD_DEQ,
    CMD_U,
    CMD_RD,
    CMD_CHK,
    CMD_W1_INIT,
    CMD_RDFWD,
    CMD_MIN,
    CMD_W2_INIT,
    CMD_SUB,
    CMD_ADD,
    CMD_EMIT
  } cmd_t;

  typedef struct packed {
    logic q_empty;
    logic v_end;
    logic found;
    logic walk_end;
    logic bad;
    logic clr_last;
    logic out_busy;
  } status_t;

endpackage
`default_nettype wire

/* design/mfek_dp.sv */
// Datapath of the maximum flow block: residual matrix, search queue, parents,
// visited marks, path walk and output register. Depends on mfek_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mfek_dp #(
  parameter int unsigned MAX_VERTICES = 16,
  parameter int unsigned CAPACITY_BITS = 16
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  mfek_pkg::cmd_t                       cmd,
  output mfek_pkg::status_t                    status,
  input  wire [mfek_pkg::VIDX_W-1:0]           in_from_vertex,
  input  wire [mfek_pkg::VIDX_W-1:0]           in_to_vertex,
  input  wire [mfek_pkg::CAP_W-1:0]            in_capacity,
  input  wire                                  cfg_valid,
  input  wire [mfek_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire [mfek_pkg::CFG_DATA_W-1:0]       cfg_data,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic [mfek_pkg::FLOW_W-1:0]          out_max_flow
);

  localparam int unsigned VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned DEPTH = MAX_VERTICES * MAX_VERTICES;
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned RW = CAPACITY_BITS + 1;
  localparam int unsigned LW = (CAPACITY_BITS < mfek_pkg::CAP_W) ? CAPACITY_BITS
                                                                 : mfek_pkg::CAP_W;
  localparam int unsigned FW = mfek_pkg::FLOW_W;

  logic [RW-1:0] res_mem [DEPTH];
  logic [VW-1:0] par_mem [MAX_VERTICES];
  logic [VW-1:0] q_mem [MAX_VERTICES];

  logic [RW-1:0] res_q;
  logic [VW-1:0] par_q;
  logic [VW-1:0] q_q;

  logic [4:0] vcount_r;
  logic [3:0] src_r;
  logic [3:0] dst_r;
  logic       out_valid_r;
  logic [AW-1:0] clr_r;

  logic [FW-1:0] out_r;
  logic [CW-1:0] n_r;
  logic [FW-1:0] flow_r;
  logic [RW-1:0] bott_r;
  logic [CW-1:0] head_r;
  logic [CW-1:0] tail_r;
  logic [VW-1:0] u_r;
  logic [CW-1:0] v_r;
  logic [VW-1:0] w_r;
  logic [CW-1:0] steps_r;
  logic [MAX_VERTICES-1:0] visited_r;

  logic          res_we;
  logic [AW-1:0] res_wa;
  logic [AW-1:0] res_ra;
  logic [RW-1:0] res_wd;
  logic [CW-1:0] n_eff;
  logic          in_range;
  logic          hit;
  logic          is_dst;
  logic [VW-1:0] v_idx;
  logic [VW-1:0] src_idx;
  logic [VW-1:0] dst_idx;

  function automatic logic [AW-1:0] addr(input logic [VW-1:0] u, input logic [VW-1:0] v);
    addr = AW'(AW'(u) * AW'(MAX_VERTICES) + AW'(v));
  endfunction

  assign n_eff = (32'(vcount_r) > MAX_VERTICES) ? CW'(MAX_VERTICES) : CW'(vcount_r);
  assign in_range = (32'(in_from_vertex) < MAX_VERTICES) && (32'(in_to_vertex) < MAX_VERTICES);
  assign v_idx = v_r[VW-1:0];
  assign src_idx = VW'(src_r);
  assign dst_idx = VW'(dst_r);
  assign hit = !visited_r[v_idx] && (res_q != '0);
  assign is_dst = 32'(v_r) == 32'(dst_r);

  assign status.q_empty = head_r >= tail_r;
  assign status.v_end = v_r >= n_r;
  assign status.found = hit && is_dst;
  assign status.walk_end = (32'(w_r) == 32'(src_r)) || (steps_r >= n_r);
  assign status.bad = (32'(src_r) >= 32'(n_eff)) || (32'(dst_r) >= 32'(n_eff)) ||
                      (src_r == dst_r);
  assign status.clr_last = clr_r == AW'(DEPTH - 1);
  assign status.out_busy = out_valid_r && !out_ready;

  assign out_valid = out_valid_r;
  assign out_max_flow = out_r;

  always_comb begin
    res_we = 1'b0;
    res_wa = addr(par_q, w_r);
    res_wd = '0;
    res_ra = addr(u_r, v_idx);
    unique case (cmd)
      mfek_pkg::CMD_LOAD: begin
        res_we = in_range;
        res_wa = addr(VW'(in_from_vertex), VW'(in_to_vertex));
        res_wd = RW'(in_capacity[LW-1:0]);
      end
      mfek_pkg::CMD_CLR: begin
        res_we = 1'b1;
        res_wa = clr_r;
      end
      mfek_pkg::CMD_RDFWD: begin
        res_ra = addr(par_q, w_r);
      end
      mfek_pkg::CMD_SUB: begin
        res_we = 1'b1;
        res_wd = res_q - bott_r;
        res_ra = addr(w_r, par_q);
      end
      mfek_pkg::CMD_ADD: begin
        res_we = 1'b1;
        res_wa = addr(w_r, par_q);
        res_wd = res_q + bott_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (res_we) begin
      res_mem[res_wa] <= res_wd;
    end
    res_q <= res_mem[res_ra];
  end

  always_ff @(posedge clk) begin
    if (cmd == mfek_pkg::CMD_CHK && hit) begin
      par_mem[v_idx] <= u_r;
    end
    par_q <= par_mem[w_r];
  end

  always_ff @(posedge clk) begin
    if (cmd == mfek_pkg::CMD_BFS_START) begin
      q_mem[0] <= src_idx;
    end else if (cmd == mfek_pkg::CMD_CHK && hit && !is_dst && 32'(tail_r) < MAX_VERTICES) begin
      q_mem[tail_r[VW-1:0]] <= v_idx;
    end
    q_q <= q_mem[head_r[VW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= 5'd16;
      src_r <= 4'd0;
      dst_r <= 4'd15;
      out_valid_r <= 1'b0;
      clr_r <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          mfek_pkg::REG_VERTEX_COUNT: vcount_r <= cfg_data;
          mfek_pkg::REG_SOURCE: src_r <= cfg_data[3:0];
          mfek_pkg::REG_SINK: dst_r <= cfg_data[3:0];
          default: begin
          end
        endcase
      end
      if (cmd == mfek_pkg::CMD_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd == mfek_pkg::CMD_CLR) begin
        clr_r <= status.clr_last ? '0 : clr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd)
      mfek_pkg::CMD_INIT: begin
        n_r <= n_eff;
        flow_r <= '0;
      end
      mfek_pkg::CMD_BFS_START: begin
        visited_r <= {{(MAX_VERTICES-1){1'b0}}, 1'b1} << src_idx;
        head_r <= '0;
        tail_r <= CW'(1);
      end
      mfek_pkg::CMD_DEQ: begin
        head_r <= head_r + 1'b1;
      end
      mfek_pkg::CMD_U: begin
        u_r <= q_q;
        v_r <= '0;
      end
      mfek_pkg::CMD_CHK: begin
        if (hit && !is_dst) begin
          visited_r[v_idx] <= 1'b1;
          if (32'(tail_r) < MAX_VERTICES) begin
            tail_r <= tail_r + 1'b1;
          end
        end
        v_r <= v_r + 1'b1;
      end
      mfek_pkg::CMD_W1_INIT: begin
        w_r <= dst_idx;
        steps_r <= '0;
        bott_r <= '1;
      end
      mfek_pkg::CMD_MIN: begin
        if (res_q < bott_r) begin
          bott_r <= res_q;
        end
        w_r <= par_q;
        steps_r <= steps_r + 1'b1;
      end
      mfek_pkg::CMD_W2_INIT: begin
        flow_r <= flow_r + FW'(bott_r);
        w_r <= dst_idx;
        steps_r <= '0;
      end
      mfek_pkg::CMD_ADD: begin
        w_r <= par_q;
        steps_r <= steps_r + 1'b1;
      end
      mfek_pkg::CMD_EMIT: begin
        out_r <= status.bad ? '0 : flow_r;
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

/* design/mfek_ctrl.sv */
// Controller of the maximum flow block: sequences loading, breadth-first
// search, path walks, result and matrix clearing. Depends on mfek_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mfek_ctrl (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  input  wire                in_last,
  output logic               in_ready,
  input  mfek_pkg::status_t  status,
  output mfek_pkg::cmd_t     cmd
);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_INIT, S_BFS, S_DEQ, S_U, S_RD, S_CHK,
    S_W1, S_P1, S_F1, S_M1, S_W2, S_P2, S_F2, S_SUB, S_ADD, S_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_ready = state_r == S_IDLE;

  always_comb begin
    state_nxt = state_r;
    cmd = mfek_pkg::CMD_NOP;
    unique case (state_r)
      S_CLR: begin
        cmd = mfek_pkg::CMD_CLR;
        if (status.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd = mfek_pkg::CMD_LOAD;
          if (in_last) state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        cmd = mfek_pkg::CMD_INIT;
        state_nxt = status.bad ? S_DONE : S_BFS;
      end
      S_BFS: begin
        cmd = mfek_pkg::CMD_BFS_START;
        state_nxt = S_DEQ;
      end
      S_DEQ: begin
        if (status.q_empty) begin
          state_nxt = S_DONE;
        end else begin
          cmd = mfek_pkg::CMD_DEQ;
          state_nxt = S_U;
        end
      end
      S_U: begin
        cmd = mfek_pkg::CMD_U;
        state_nxt = S_RD;
      end
      S_RD: begin
        if (status.v_end) begin
          state_nxt = S_DEQ;
        end else begin
          cmd = mfek_pkg::CMD_RD;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        cmd = mfek_pkg::CMD_CHK;
        state_nxt = status.found ? S_W1 : S_RD;
      end
      S_W1: begin
        cmd = mfek_pkg::CMD_W1_INIT;
        state_nxt = S_P1;
      end
      S_P1: begin
        state_nxt = status.walk_end ? S_W2 : S_F1;
      end
      S_F1: begin
        cmd = mfek_pkg::CMD_RDFWD;
        state_nxt = S_M1;
      end
      S_M1: begin
        cmd = mfek_pkg::CMD_MIN;
        state_nxt = S_P1;
      end
      S_W2: begin
        cmd = mfek_pkg::CMD_W2_INIT;
        state_nxt = S_P2;
      end
      S_P2: begin
        state_nxt = status.walk_end ? S_BFS : S_F2;
      end
      S_F2: begin
        cmd = mfek_pkg::CMD_RDFWD;
        state_nxt = S_SUB;
      end
      S_SUB: begin
        cmd = mfek_pkg::CMD_SUB;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        cmd = mfek_pkg::CMD_ADD;
        state_nxt = S_P2;
      end
      S_DONE: begin
        if (!status.out_busy) begin
          cmd = mfek_pkg::CMD_EMIT;
          state_nxt = S_CLR;
        end
      end
      default: state_nxt = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

/* design/max_flow_edmonds_karp.sv */
// Top level of the Edmonds-Karp maximum flow block.
// Instantiates mfek_ctrl and mfek_dp; depends on mfek_pkg.
//
//   Channel  Direction  Ports
//   in       input      in_valid, in_ready, in_from_vertex, in_to_vertex, in_capacity, in_last
//   out      output     out_valid, out_ready, out_max_flow
//   cfg      input      cfg_valid, cfg_ready, cfg_index, cfg_data
//
// Each accepted request loads one matrix entry; the request with in_last set starts the search.
// After a setup step, each breadth-first search that reaches the sink is followed by two
// walks of the augmenting path: one finds the bottleneck, the other updates the residuals.
// After each result, and after reset, a clearing pass zeroes all MAX_VERTICES squared
// matrix entries; in_ready stays low meanwhile. Config is always ready.
`timescale 1ns / 1ps
`default_nettype none
module max_flow_edmonds_karp #(
  parameter int unsigned MAX_VERTICES = 16,
  parameter int unsigned CAPACITY_BITS = 16
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire [mfek_pkg::VIDX_W-1:0]         in_from_vertex,
  input  wire [mfek_pkg::VIDX_W-1:0]         in_to_vertex,
  input  wire [mfek_pkg::CAP_W-1:0]          in_capacity,
  input  wire                                in_last,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic [mfek_pkg::FLOW_W-1:0]        out_max_flow,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire [mfek_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [mfek_pkg::CFG_DATA_W-1:0]     cfg_data
);

  mfek_pkg::cmd_t    cmd;
  mfek_pkg::status_t status;

  assign cfg_ready = 1'b1;

  mfek_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_last),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  mfek_dp #(
    .MAX_VERTICES  (MAX_VERTICES),
    .CAPACITY_BITS (CAPACITY_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_from_vertex (in_from_vertex),
    .in_to_vertex   (in_to_vertex),
    .in_capacity    (in_capacity),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_max_flow   (out_max_flow)
  );

endmodule
`default_nettype wire
